// ===== rtl/fcs_pkg.sv =====
// Shared types and constants for the filtered column statistics block.
package fcs_pkg;

    localparam int SUM_BITS   = 64;
    localparam int FRAC_BITS  = 16;
    localparam int MEAN_BITS  = 48;
    localparam int NUM_BITS   = SUM_BITS + FRAC_BITS;
    localparam int STEP_BITS  = $clog2(NUM_BITS + 1);

    localparam logic [MEAN_BITS-1:0] MEAN_POS_CAP = {1'b0, {(MEAN_BITS-1){1'b1}}};
    localparam logic [MEAN_BITS-1:0] MEAN_NEG_CAP = {1'b1, {(MEAN_BITS-1){1'b0}}};

    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    // Filter mode codes
    localparam logic [1:0] FILTER_ALL = 2'd0;
    localparam logic [1:0] FILTER_LT  = 2'd1;
    localparam logic [1:0] FILTER_GT  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_NULL_SENTINEL = 2'd0;
    localparam logic [1:0] REG_FILTER_MODE   = 2'd1;
    localparam logic [1:0] REG_FILTER_VALUE  = 2'd2;

    typedef struct packed {
        logic acc;        // fold the offered item into the running state
        logic close;      // item is last: snapshot totals and clear
        logic div_start;  // launch the mean division
        logic load_out;   // load the result register
    } t_ctrl_cmd;

    typedef struct packed {
        logic div_busy;
    } t_ctrl_sts;

endpackage

// ===== rtl/filtered_column_stats.sv =====
// Top level of the filtered column statistics block with its register port.
//
// Input channel (i_valid/o_ready): one signed column value per transfer, with
// i_last on the final element. Values equal to the null sentinel are skipped;
// the rest pass the filter (all, less than, or greater than filter value) and
// update the running min, max, saturating sum and pass count. Every row,
// nulls included, bumps the row count.
// Output channel (o_valid/i_ready): one transfer per column, carrying min,
// max, sum, both counts, the mean (signed, 16 fraction bits, truncated) and
// a has-data flag.
// Flow: non-last values are accepted back to back. A last value starts an
// 80-step bit-serial division for the mean; the result appears once that is
// done and the result register is free; input ready returns in that same cycle.
// The result register holds while the receiver stalls; a new column may
// stream in meanwhile, but its result waits in the divider for the register.
// Reset (synchronous, active low) clears the running state, drops o_valid and
// restores the registers: null sentinel -2^31, filter mode 0, filter value 0.
// Registers at byte addresses 0 (null sentinel), 4 (filter mode), 8 (filter
// value); write them only while the block is idle.
module filtered_column_stats #(
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_value,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_min_value,
    output logic [31:0] o_max_value,
    output logic [63:0] o_sum_value,
    output logic [31:0] o_passed_count,
    output logic [31:0] o_row_count,
    output logic [47:0] o_mean_value,
    output logic        o_has_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fcs_pkg::*;

    logic [31:0] r_null_sentinel;
    logic [1:0]  r_filter_mode;
    logic [31:0] r_filter_value;
    logic [1:0]  w_reg_idx;
    logic        w_cfg_wr;

    t_ctrl_cmd   w_cmd;
    t_ctrl_sts   w_sts;

    // Register port: zero wait states, word-aligned registers
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_null_sentinel <= 32'h8000_0000;
            r_filter_mode   <= FILTER_ALL;
            r_filter_value  <= '0;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_NULL_SENTINEL: r_null_sentinel <= pwdata;
                REG_FILTER_MODE:   r_filter_mode   <= pwdata[1:0];
                REG_FILTER_VALUE:  r_filter_value  <= pwdata;
                default: begin
                    // drop writes past the register list
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_NULL_SENTINEL: prdata = r_null_sentinel;
            REG_FILTER_MODE:   prdata = {30'd0, r_filter_mode};
            REG_FILTER_VALUE:  prdata = r_filter_value;
            default:           prdata = '0;
        endcase
    end

    // Controller: owns the handshakes and the sequencing
    fcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_last   (i_last),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Datapath: statistics, divider and result register
    fcs_dp #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_value         (i_value),
        .i_null_sentinel (r_null_sentinel),
        .i_filter_mode   (r_filter_mode),
        .i_filter_value  (r_filter_value),
        .o_min_value     (o_min_value),
        .o_max_value     (o_max_value),
        .o_sum_value     (o_sum_value),
        .o_passed_count  (o_passed_count),
        .o_row_count     (o_row_count),
        .o_mean_value    (o_mean_value),
        .o_has_data      (o_has_data)
    );

    // A last transfer must drop input ready after it
    a_last_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_last) |=> !o_ready)
        else $error("input still ready after last transfer");

    // An empty column reports zero sum and zero mean
    a_empty_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_has_data) |-> ((o_mean_value == '0) && (o_sum_value == '0)))
        else $error("empty column with nonzero sum or mean");

    // Reset drops the output valid
    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

// ===== rtl/fcs_div.sv =====
// Bit-serial restoring divider for the fixed-point mean.
module fcs_div #(
    parameter int COUNT_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [fcs_pkg::SUM_BITS-1:0]     i_dividend,
    input  logic [COUNT_BITS-1:0]            i_divisor,
    output logic                             o_busy,
    output logic [fcs_pkg::MEAN_BITS-1:0]    o_quot,
    output logic                             o_ovf
);
    import fcs_pkg::*;

    logic [NUM_BITS-1:0]   r_num;
    logic [COUNT_BITS-1:0] r_den;
    logic [COUNT_BITS-1:0] r_rem;
    logic [MEAN_BITS-1:0]  r_quot;
    logic                  r_ovf;
    logic [STEP_BITS-1:0]  r_cnt;
    logic                  r_busy;

    logic [COUNT_BITS:0]   w_trial;
    logic [COUNT_BITS:0]   w_diff;
    logic                  w_ge;

    assign w_trial = {r_rem, r_num[NUM_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = ~w_diff[COUNT_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= STEP_BITS'(NUM_BITS);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != STEP_BITS'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= {i_dividend, {FRAC_BITS{1'b0}}};
            r_den  <= i_divisor;
            r_rem  <= '0;
            r_quot <= '0;
            r_ovf  <= 1'b0;
        end else if (r_busy) begin
            r_num  <= {r_num[NUM_BITS-2:0], 1'b0};
            r_rem  <= w_ge ? w_diff[COUNT_BITS-1:0] : w_trial[COUNT_BITS-1:0];
            // a one pushed out of the top means the quotient needs more than 48 bits
            r_ovf  <= r_ovf | r_quot[MEAN_BITS-1];
            r_quot <= {r_quot[MEAN_BITS-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
    assign o_ovf  = r_ovf;

endmodule

// ===== rtl/fcs_dp.sv =====
// Datapath: filter, running statistics, snapshot, mean and result register.
module fcs_dp #(
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fcs_pkg::t_ctrl_cmd            i_cmd,
    output fcs_pkg::t_ctrl_sts            o_sts,
    input  logic [31:0]                   i_value,
    input  logic [31:0]                   i_null_sentinel,
    input  logic [1:0]                    i_filter_mode,
    input  logic [31:0]                   i_filter_value,
    output logic [31:0]                   o_min_value,
    output logic [31:0]                   o_max_value,
    output logic [63:0]                   o_sum_value,
    output logic [31:0]                   o_passed_count,
    output logic [31:0]                   o_row_count,
    output logic [47:0]                   o_mean_value,
    output logic                          o_has_data
);
    import fcs_pkg::*;

    localparam logic signed [VALUE_BITS-1:0] V_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] V_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [COUNT_BITS-1:0]        C_MAX = {COUNT_BITS{1'b1}};

    logic signed [VALUE_BITS-1:0] w_v, w_null, w_fv;
    logic signed [SUM_BITS-1:0]   w_v_ext, w_sum_raw;
    logic                         w_mode_pass, w_pass, w_sum_ovf;

    logic signed [VALUE_BITS-1:0] r_min, r_max, n_min, n_max;
    logic signed [SUM_BITS-1:0]   r_sum, n_sum;
    logic [COUNT_BITS-1:0]        r_pcnt, r_rcnt, n_pcnt, n_rcnt;

    logic signed [VALUE_BITS-1:0] r_st_min, r_st_max;
    logic signed [SUM_BITS-1:0]   r_st_sum;
    logic [COUNT_BITS-1:0]        r_st_pcnt, r_st_rcnt;

    logic [SUM_BITS-1:0]          w_mag;
    logic                         w_div_busy, w_div_ovf;
    logic [MEAN_BITS-1:0]         w_quot, w_m, w_mean;

    logic [31:0]                  r_o_min, r_o_max, r_o_pcnt, r_o_rcnt;
    logic [63:0]                  r_o_sum;
    logic [47:0]                  r_o_mean;
    logic                         r_o_has;

    // narrow to the datapath width and sign-extend
    assign w_v    = VALUE_BITS'(signed'(i_value));
    assign w_null = VALUE_BITS'(signed'(i_null_sentinel));
    assign w_fv   = VALUE_BITS'(signed'(i_filter_value));

    always_comb begin
        case (i_filter_mode)
            FILTER_LT: w_mode_pass = (w_v < w_fv);
            FILTER_GT: w_mode_pass = (w_fv < w_v);
            default:   w_mode_pass = 1'b1;
        endcase
    end

    assign w_pass    = (w_v != w_null) && w_mode_pass;
    assign w_v_ext   = SUM_BITS'(w_v);
    assign w_sum_raw = r_sum + w_v_ext;
    assign w_sum_ovf = (r_sum[SUM_BITS-1] == w_v_ext[SUM_BITS-1]) &&
                       (w_sum_raw[SUM_BITS-1] != r_sum[SUM_BITS-1]);

    always_comb begin
        n_rcnt = (r_rcnt != C_MAX) ? r_rcnt + 1'b1 : r_rcnt;
        n_min  = r_min;
        n_max  = r_max;
        n_sum  = r_sum;
        n_pcnt = r_pcnt;
        if (w_pass) begin
            if (w_v < r_min) begin
                n_min = w_v;
            end
            if (r_max < w_v) begin
                n_max = w_v;
            end
            if (w_sum_ovf) begin
                n_sum = r_sum[SUM_BITS-1] ? SUM_MIN : SUM_MAX;
            end else begin
                n_sum = w_sum_raw;
            end
            if (r_pcnt != C_MAX) begin
                n_pcnt = r_pcnt + 1'b1;
            end
        end
    end

    // running state: clear after the column closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= V_MAX;
            r_max  <= V_MIN;
            r_sum  <= '0;
            r_pcnt <= '0;
            r_rcnt <= '0;
        end else if (i_cmd.acc) begin
            if (i_cmd.close) begin
                r_min  <= V_MAX;
                r_max  <= V_MIN;
                r_sum  <= '0;
                r_pcnt <= '0;
                r_rcnt <= '0;
            end else begin
                r_min  <= n_min;
                r_max  <= n_max;
                r_sum  <= n_sum;
                r_pcnt <= n_pcnt;
                r_rcnt <= n_rcnt;
            end
        end
    end

    // column totals held while the mean is divided out
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc && i_cmd.close) begin
            r_st_min  <= n_min;
            r_st_max  <= n_max;
            r_st_sum  <= n_sum;
            r_st_pcnt <= n_pcnt;
            r_st_rcnt <= n_rcnt;
        end
    end

    assign w_mag = r_st_sum[SUM_BITS-1] ? (SUM_BITS'(0) - r_st_sum) : r_st_sum;

    fcs_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_mag),
        .i_divisor  (r_st_pcnt),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot),
        .o_ovf      (w_div_ovf)
    );

    assign o_sts.div_busy = w_div_busy;

    // saturate the magnitude, then apply the sign; an empty column gives zero
    always_comb begin
        w_m = w_div_ovf ? MEAN_NEG_CAP : w_quot;
        if (r_st_pcnt == '0) begin
            w_mean = '0;
        end else if (r_st_sum[SUM_BITS-1]) begin
            w_mean = (w_m >= MEAN_NEG_CAP) ? MEAN_NEG_CAP : (MEAN_BITS'(0) - w_m);
        end else begin
            w_mean = w_m[MEAN_BITS-1] ? MEAN_POS_CAP : w_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_min  <= 32'(r_st_min);
            r_o_max  <= 32'(r_st_max);
            r_o_sum  <= (r_st_pcnt != '0) ? r_st_sum : '0;
            r_o_pcnt <= 32'(r_st_pcnt);
            r_o_rcnt <= 32'(r_st_rcnt);
            r_o_mean <= w_mean;
            r_o_has  <= (r_st_pcnt != '0);
        end
    end

    assign o_min_value    = r_o_min;
    assign o_max_value    = r_o_max;
    assign o_sum_value    = r_o_sum;
    assign o_passed_count = r_o_pcnt;
    assign o_row_count    = r_o_rcnt;
    assign o_mean_value   = r_o_mean;
    assign o_has_data     = r_o_has;

endmodule

// ===== rtl/fcs_ctrl.sv =====
// Controller: sequences accumulation, mean division and result hand-off.
module fcs_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_last,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  fcs_pkg::t_ctrl_sts   i_sts,
    output fcs_pkg::t_ctrl_cmd   o_cmd
);
    import fcs_pkg::*;

    typedef enum logic [2:0] {
        S_ACC   = 3'b001,
        S_START = 3'b010,
        S_DIV   = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = ~r_out_valid | i_out_ready;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.acc       = (r_state == S_ACC) && i_in_valid;
        o_cmd.close     = o_cmd.acc && i_in_last;
        o_cmd.div_start = (r_state == S_START);
        o_cmd.load_out  = (r_state == S_DIV) && !i_sts.div_busy && w_out_free;
        case (r_state)
            S_ACC: begin
                if (o_cmd.close) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (o_cmd.load_out) begin
                    n_state = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    assign n_out_valid = o_cmd.load_out | (r_out_valid & ~i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_ACC);
    assign o_out_valid = r_out_valid;

endmodule
